>>> design/gcs_pkg.sv
// Package for the Gronsfeld cipher stream: widths, register indexes, alphabet bounds, shift function.
package gcs_pkg;

  localparam int unsigned MaxKeyDigitsDefault = 16;
  localparam int unsigned CharW   = 16;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned KeyLenW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  localparam logic [CfgIdxW-1:0] RegKeyDigits  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLength  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDecrypt    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBinary     = 2'd3;

  localparam logic [DigitW-1:0] MaxDigit = 4'd9;

  localparam logic [CharW-1:0] LatinSize    = 16'd26;
  localparam logic [CharW-1:0] CyrillicSize = 16'd32;
  localparam logic [CharW-1:0] LowerLatinLo = 16'h0061;
  localparam logic [CharW-1:0] LowerLatinHi = 16'h007A;
  localparam logic [CharW-1:0] UpperLatinLo = 16'h0041;
  localparam logic [CharW-1:0] UpperLatinHi = 16'h005A;
  localparam logic [CharW-1:0] LowerCyrLo   = 16'h0430;
  localparam logic [CharW-1:0] LowerCyrHi   = 16'h044F;
  localparam logic [CharW-1:0] UpperCyrLo   = 16'h0410;
  localparam logic [CharW-1:0] UpperCyrHi   = 16'h042F;

  // Shift one code unit by +/- digit; in text mode letters wrap inside their alphabet.
  function automatic logic [CharW-1:0] shift_char(
    input logic [CharW-1:0]  c,
    input logic [DigitW-1:0] digit,
    input logic              decrypt,
    input logic              binary
  );
    logic [CharW-1:0] t;
    logic [CharW-1:0] lo;
    logic [CharW-1:0] hi;
    logic [CharW-1:0] size;
    logic             letter;
    begin
      t = decrypt ? (c - CharW'(digit)) : (c + CharW'(digit));
      letter = 1'b1;
      lo = LowerLatinLo;
      hi = LowerLatinHi;
      size = LatinSize;
      if (c >= LowerLatinLo && c <= LowerLatinHi) begin
        lo = LowerLatinLo; hi = LowerLatinHi; size = LatinSize;
      end else if (c >= LowerCyrLo && c <= LowerCyrHi) begin
        lo = LowerCyrLo; hi = LowerCyrHi; size = CyrillicSize;
      end else if (c >= UpperLatinLo && c <= UpperLatinHi) begin
        lo = UpperLatinLo; hi = UpperLatinHi; size = LatinSize;
      end else if (c >= UpperCyrLo && c <= UpperCyrHi) begin
        lo = UpperCyrLo; hi = UpperCyrHi; size = CyrillicSize;
      end else begin
        letter = 1'b0;
      end
      // letters sit well above zero, so t never wraps past 16 bits here
      if (!binary && letter) begin
        if (t > hi) begin
          t = t - size;
        end else if (t < lo) begin
          t = t + size;
        end
      end
      return t;
    end
  endfunction

endpackage

>>> design/gronsfeld_cipher_stream.sv
// Gronsfeld cipher stream: one character code unit in, one shifted unit out per item.
// The result is registered: result valid follows in the cycle after input accept.
// Throughput: one item per cycle; input stalls only while a held result is stalled.
// Key position and result valid clear on reset; key digits 0, key length 1,
// encrypt and text mode after reset.
module gronsfeld_cipher_stream #(
  parameter int unsigned MAX_KEY_DIGITS = gcs_pkg::MaxKeyDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gcs_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gcs_pkg::CharW-1:0]     char_in_i,
  input  logic                          first_of_message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gcs_pkg::CharW-1:0]     char_out_o
);

  localparam int unsigned KeyW = MAX_KEY_DIGITS * gcs_pkg::DigitW;
  localparam int unsigned PosW = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;
  localparam logic [gcs_pkg::KeyLenW-1:0] MaxLen = gcs_pkg::KeyLenW'(MAX_KEY_DIGITS);

  logic [KeyW-1:0]                 key_q;
  logic [gcs_pkg::KeyLenW-1:0]     key_len_q;
  logic                            decrypt_q;
  logic                            binary_q;
  logic [PosW-1:0]                 pos_q, pos_d;
  logic                            out_valid_q, out_valid_d;
  logic [gcs_pkg::CharW-1:0]       char_out_q, char_out_d;

  logic                            in_accept;
  logic [gcs_pkg::KeyLenW-1:0]     eff_len;
  logic [gcs_pkg::KeyLenW-1:0]     cur_pos;
  logic [gcs_pkg::KeyLenW-1:0]     next_pos;
  logic [gcs_pkg::DigitW-1:0]      raw_digit;
  logic [gcs_pkg::DigitW-1:0]      digit;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;

  always_comb begin
    priority if (key_len_q == '0) begin
      eff_len = gcs_pkg::KeyLenW'(1);
    end else if (key_len_q > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = key_len_q;
    end
  end

  always_comb begin
    cur_pos = first_of_message_i ? '0 : gcs_pkg::KeyLenW'(pos_q);
    // position left over from a longer key restarts at digit zero
    if (cur_pos >= eff_len) begin
      cur_pos = '0;
    end
    raw_digit = key_q[gcs_pkg::DigitW * cur_pos[PosW-1:0] +: gcs_pkg::DigitW];
    digit = (raw_digit > gcs_pkg::MaxDigit) ? gcs_pkg::MaxDigit : raw_digit;
    next_pos = cur_pos + gcs_pkg::KeyLenW'(1);
    if (next_pos >= eff_len) begin
      next_pos = '0;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_out_d  = char_out_q;
    if (in_accept) begin
      pos_d       = next_pos[PosW-1:0];
      out_valid_d = 1'b1;
      char_out_d  = gcs_pkg::shift_char(char_in_i, digit, decrypt_q, binary_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      key_len_q   <= gcs_pkg::KeyLenW'(1);
      decrypt_q   <= 1'b0;
      binary_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gcs_pkg::RegKeyDigits: key_q     <= cfg_data_i[KeyW-1:0];
          gcs_pkg::RegKeyLength: key_len_q <= cfg_data_i[gcs_pkg::KeyLenW-1:0];
          gcs_pkg::RegDecrypt:   decrypt_q <= cfg_data_i[0];
          gcs_pkg::RegBinary:    binary_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_out_q <= char_out_d;
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < MAX_KEY_DIGITS)
    else $error("key position beyond key storage");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && first_of_message_i && eff_len > gcs_pkg::KeyLenW'(1) |=> pos_q == PosW'(1))
    else $error("first item of message did not use digit zero");

  a_single_digit_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && eff_len == gcs_pkg::KeyLenW'(1) |=> pos_q == '0)
    else $error("one-digit key moved position");

  a_held_result_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o))
    else $error("stalled result lost or changed");

endmodule

>>> tb/tb_gronsfeld_cipher_stream.sv
// Self-checking testbench for gronsfeld_cipher_stream: directed table, then random messages.
`timescale 1ns / 1ps

module tb_gronsfeld_cipher_stream;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [gcs_pkg::CfgIdxW-1:0] idx;
    logic [gcs_pkg::CfgW-1:0]    data;
    logic [gcs_pkg::CharW-1:0]   ch;
    logic                        first;
    logic                        known;
    logic [gcs_pkg::CharW-1:0]   want;
  } dir_row_t;

  localparam int unsigned NumRows = 32;
  localparam int unsigned PendDepth = 16;

  // known rows carry the shifted char; the rest rely on the shift model
  localparam dir_row_t DirTab [NumRows] = '{
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
    '{RowCfg,  gcs_pkg::RegKeyDigits, 64'h9, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h007A, 1'b1, 1'b1, 16'h0069},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h005A, 1'b0, 1'b1, 16'h0049},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h044F, 1'b0, 1'b1, 16'h0438},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h042F, 1'b0, 1'b1, 16'h0418},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'hFFFF, 1'b0, 1'b1, 16'h0008},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0060, 1'b0, 1'b1, 16'h0069},
    '{RowCfg,  gcs_pkg::RegDecrypt,   64'h1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0061, 1'b0, 1'b1, 16'h0072},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0041, 1'b0, 1'b1, 16'h0052},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0430, 1'b0, 1'b1, 16'h0447},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0410, 1'b0, 1'b1, 16'h0427},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0000, 1'b0, 1'b1, 16'hFFF7},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h007B, 1'b0, 1'b1, 16'h0072},
    '{RowCfg,  gcs_pkg::RegBinary,    64'h1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h007A, 1'b0, 1'b1, 16'h0071},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0000, 1'b0, 1'b1, 16'hFFF7},
    '{RowCfg,  gcs_pkg::RegBinary,    64'h0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowCfg,  gcs_pkg::RegDecrypt,   64'h0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowCfg,  gcs_pkg::RegKeyDigits, 64'hFEDC_BA98_7654_3210, 16'h0000, 1'b0, 1'b0,
      16'h0000},
    '{RowCfg,  gcs_pkg::RegKeyLength, 64'd16, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0078, 1'b1, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0079, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h043F, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h004D, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h041F, 1'b0, 1'b0, 16'h0000},
    // shrink the key below the current position: digit zero is used
    '{RowCfg,  gcs_pkg::RegKeyLength, 64'd3, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0070, 1'b0, 1'b0, 16'h0000},
    '{RowCfg,  gcs_pkg::RegKeyLength, 64'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{RowItem, gcs_pkg::RegKeyDigits, 64'h0, 16'h0063, 1'b0, 1'b0, 16'h0000}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [gcs_pkg::CfgIdxW-1:0] cfg_index_i = gcs_pkg::RegKeyDigits;
  logic [gcs_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [gcs_pkg::CharW-1:0]   char_in_i = '0;
  logic                        first_of_message_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [gcs_pkg::CharW-1:0]   char_out_o;

  // typed expectation travels with the item
  logic                        want_known = 1'b0;
  logic [gcs_pkg::CharW-1:0]   want_char = '0;

  // shadow copy of the cipher settings and key position
  logic [gcs_pkg::CfgW-1:0]    key_m = '0;
  logic [gcs_pkg::KeyLenW-1:0] key_len_m = 5'd1;
  logic                        decrypt_m = 1'b0;
  logic                        binary_m = 1'b0;
  logic [3:0]                  key_pos_m = '0;

  // expected chars in accept order, ring indexed by running counts
  logic [gcs_pkg::CharW-1:0]   pending_chars [PendDepth];
  int                          pend_wr = 0;
  int                          pend_rd = 0;
  int                          items_sent = 0;
  int                          chars_seen = 0;
  int                          errors = 0;
  int                          idle_pct = 0;
  int                          stall_pct = 0;

  gronsfeld_cipher_stream uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .char_in_i          (char_in_i),
    .first_of_message_i (first_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .char_out_o         (char_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Shift one char by the current key digit and step the key position.
  function automatic logic [gcs_pkg::CharW-1:0] encipher_next(
    input logic [gcs_pkg::CharW-1:0] c,
    input logic                      first
  );
    int len;
    int pos;
    int digit;
    int s;
    int v;
    int lo;
    int sz;
    int t;
    len = int'(key_len_m);
    if (len < 1) len = 1;
    if (len > int'(gcs_pkg::MaxKeyDigitsDefault)) len = int'(gcs_pkg::MaxKeyDigitsDefault);
    pos = first ? 0 : int'(key_pos_m);
    if (pos >= len) pos = 0;
    digit = int'(key_m[4*pos +: 4]);
    if (digit > 9) digit = 9;
    s = decrypt_m ? -digit : digit;
    v = int'(c);
    lo = 0;
    sz = 0;
    if (!binary_m) begin
      if (v >= int'(gcs_pkg::LowerLatinLo) && v <= int'(gcs_pkg::LowerLatinHi)) begin
        lo = int'(gcs_pkg::LowerLatinLo); sz = 26;
      end else if (v >= int'(gcs_pkg::LowerCyrLo) && v <= int'(gcs_pkg::LowerCyrHi)) begin
        lo = int'(gcs_pkg::LowerCyrLo); sz = 32;
      end else if (v >= int'(gcs_pkg::UpperLatinLo) && v <= int'(gcs_pkg::UpperLatinHi)) begin
        lo = int'(gcs_pkg::UpperLatinLo); sz = 26;
      end else if (v >= int'(gcs_pkg::UpperCyrLo) && v <= int'(gcs_pkg::UpperCyrHi)) begin
        lo = int'(gcs_pkg::UpperCyrLo); sz = 32;
      end
    end
    t = v + s;
    if (sz != 0) begin
      if (t > lo + sz - 1) t = v - sz + s;
      else if (t < lo) t = v + sz + s;
    end
    pos = pos + 1;
    if (pos >= len) pos = 0;
    key_pos_m = 4'(pos);
    return gcs_pkg::CharW'(t);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    logic [gcs_pkg::CharW-1:0] pred;
    logic [gcs_pkg::CharW-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gcs_pkg::RegKeyDigits: key_m = cfg_data_i;
          gcs_pkg::RegKeyLength: key_len_m = cfg_data_i[gcs_pkg::KeyLenW-1:0];
          gcs_pkg::RegDecrypt:   decrypt_m = cfg_data_i[0];
          gcs_pkg::RegBinary:    binary_m = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        pred = encipher_next(char_in_i, first_of_message_i);
        pending_chars[pend_wr % PendDepth] = want_known ? want_char : pred;
        pend_wr++;
      end
      if (out_valid_o && !out_stall_i) begin
        chars_seen++;
        if (pend_wr == pend_rd) begin
          errors++;
          $display("%0t: char_out expected none actual %h", $time, char_out_o);
        end else begin
          want = pending_chars[pend_rd % PendDepth];
          pend_rd++;
          if (char_out_o !== want) begin
            errors++;
            $display("%0t: char_out expected %h actual %h", $time, want, char_out_o);
          end
        end
      end
    end
  end

  task automatic send_item(input logic [gcs_pkg::CharW-1:0] ch, input logic first,
                           input logic known, input logic [gcs_pkg::CharW-1:0] want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i <= ch;
    first_of_message_i <= first;
    want_known <= known;
    want_char <= want;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Let every outstanding item come out before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (chars_seen != items_sent) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gcs_pkg::CfgIdxW-1:0] idx,
                           input logic [gcs_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Mostly letters and alphabet edges, with full-range units mixed in.
  function automatic logic [gcs_pkg::CharW-1:0] rand_char();
    logic [gcs_pkg::CharW-1:0] c;
    case ($urandom_range(0, 6))
      0: c = gcs_pkg::LowerLatinLo - 16'd1 + gcs_pkg::CharW'($urandom_range(0, 27));
      1: c = gcs_pkg::UpperLatinLo - 16'd1 + gcs_pkg::CharW'($urandom_range(0, 27));
      2: c = gcs_pkg::LowerCyrLo - 16'd1 + gcs_pkg::CharW'($urandom_range(0, 33));
      3: c = gcs_pkg::UpperCyrLo - 16'd1 + gcs_pkg::CharW'($urandom_range(0, 33));
      6: c = $urandom_range(0, 1) ? gcs_pkg::CharW'($urandom_range(0, 9))
                                  : 16'hFFFF - gcs_pkg::CharW'($urandom_range(0, 9));
      default: c = gcs_pkg::CharW'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    int n;
    int msg_len;
    logic [gcs_pkg::CfgW-1:0] key;
    logic [gcs_pkg::CfgW-1:0] len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      if (DirTab[i].kind == RowCfg) begin
        drain();
        write_reg(DirTab[i].idx, DirTab[i].data);
        cfg_we_i <= 1'b0;
      end else begin
        send_item(DirTab[i].ch, DirTab[i].first, DirTab[i].known, DirTab[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      case (p)
        0: key = '1;
        1: key = '0;
        4: key = 64'h9999_9999_9999_9999;
        default: key = {$urandom, $urandom};
      endcase
      case (p)
        2: len = 64'd16;
        3: len = 64'd1;
        5: len = 64'd0;
        6: len = 64'd31;
        default: len = gcs_pkg::CfgW'($urandom_range(0, 31));
      endcase
      write_reg(gcs_pkg::RegKeyDigits, key);
      write_reg(gcs_pkg::RegKeyLength, len);
      write_reg(gcs_pkg::RegDecrypt, gcs_pkg::CfgW'(p % 2));
      write_reg(gcs_pkg::RegBinary, gcs_pkg::CfgW'(p == 3 || p == 6));
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      n = 0;
      while (n < 90) begin
        msg_len = $urandom_range(1, 20);
        for (int k = 0; k < msg_len; k++) begin
          send_item(rand_char(), (k == 0) || ($urandom_range(0, 40) == 0), 1'b0, '0);
          n++;
        end
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (pend_wr != pend_rd) begin
      errors++;
      $display("%0t: %0d chars never came out", $time, pend_wr - pend_rd);
    end
    if (errors == 0) begin
      $display("gronsfeld_cipher_stream verification clean");
    end else begin
      $display("gronsfeld_cipher_stream verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("gronsfeld_cipher_stream verification failed");
    $finish;
  end

endmodule

>>> gronsfeld_cipher_stream.f
design/gcs_pkg.sv
design/gronsfeld_cipher_stream.sv
tb/tb_gronsfeld_cipher_stream.sv
